// ----- hw/rtl/mf3_pkg.sv -----
// Package of the 3x3 median filter: sizes, register indexes and the job record.
`default_nettype none
package mf3_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 8;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 12;
	localparam int CFG_W_W    = 11;
	localparam int CFG_H_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int JOB_DEPTH  = 4;
	localparam int JOB_PTR_W  = 2;
	localparam int JOB_CNT_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

	typedef logic [8:0][PIX_W-1:0] window_t;

	// One input pixel's worth of pending results: window plus row/column choices.
	typedef struct packed {
		window_t                    win;
		logic [1:0][2:0]            rmask;
		logic [1:0][ROW_W-1:0]      rnum;
		logic [1:0]                 rlast;
		logic                       nr2;
		logic [1:0][2:0]            cmask;
		logic [1:0][COL_W-1:0]      cnum;
		logic [1:0]                 clast;
		logic                       nc2;
	} job_t;
endpackage
`default_nettype wire

// ----- hw/rtl/mf3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/mf3_median.sv -----
// Rank-select median of the masked cells of a 3x3 window.
`default_nettype none
module mf3_median (
	input  wire mf3_pkg::window_t              vals,
	input  wire logic [8:0]                    mask,
	output logic      [mf3_pkg::PIX_W-1:0]     med
);
	logic [3:0] n;
	logic [3:0] rank [9];

	always_comb begin
		n = 4'($countones(mask));
		for (int i = 0; i < 9; i++) begin
			rank[i] = 4'd0;
			for (int j = 0; j < 9; j++) begin
				if (mask[j] && ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)))) begin
					rank[i] = rank[i] + 4'd1;
				end
			end
		end
		med = '0;
		for (int i = 0; i < 9; i++) begin
			if (mask[i] && (rank[i] == (n >> 1))) begin
				med = vals[i];
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/median_filter_3x3_top.sv -----
// Top level of the streaming 3x3 median filter.
`default_nettype none
// Pixels of one 8-bit plane enter in raster order, one transfer per cycle when
// the result side keeps up. Each pixel leaves 0 to 4 results behind it: the
// median of the in-image part of the 3x3 neighbourhood for the centre one row
// and one column back, plus the right-edge column at row ends and the whole
// bottom row at the last row. A pixel passes through the line-store read
// stage, then its result choices wait in a four-entry job queue; the output
// sequencer drains one result per cycle, so the rate is one pixel per cycle
// except where a pixel owes two or four results (row ends, the last row), where
// the single median unit and output register set the pace of one result per
// cycle. Two 1024 x 8 line stores keep the previous rows; their contents before
// first write never reach a result. A configuration transfer (index 0 width,
// index 1 height, any other index only restarts) restarts the frame and must be
// issued only while the block is idle. Zero widths and heights act as 1, widths
// of 1025 to 2047 and heights above 4096 are clamped. cfg_ready is always high.
module median_filter_3x3_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              pixel_valid,
	output logic                                   pixel_ready,
	input  wire logic [mf3_pkg::PIX_W-1:0]         pixel_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [mf3_pkg::PIX_W-1:0]         median_out,
	output logic      [mf3_pkg::ROW_W-1:0]         out_row,
	output logic      [mf3_pkg::COL_W-1:0]         out_col,
	output logic                                   frame_done
);
	// configuration
	logic [mf3_pkg::CFG_W_W-1:0] cfg_w_q;
	logic [mf3_pkg::CFG_H_W-1:0] cfg_h_q;
	logic [mf3_pkg::CFG_W_W-1:0] uw;
	logic [mf3_pkg::CFG_H_W-1:0] uh;
	logic                        cfg_xfer;

	// input position and read stage
	logic [mf3_pkg::COL_W-1:0] col_q;
	logic [mf3_pkg::ROW_W-1:0] row_q;
	logic                      in_xfer;
	logic                      s1_valid;
	logic [mf3_pkg::PIX_W-1:0] px_s1;
	logic [mf3_pkg::COL_W-1:0] col_s1;
	logic [mf3_pkg::ROW_W-1:0] row_s1;
	logic                      fwd_s1;
	logic [mf3_pkg::PIX_W-1:0] fwd_a_s1;
	logic [mf3_pkg::PIX_W-1:0] fwd_b_s1;
	logic [mf3_pkg::PIX_W-1:0] ram_a_rd;
	logic [mf3_pkg::PIX_W-1:0] ram_b_rd;
	logic [mf3_pkg::PIX_W-1:0] a_eff;
	logic [mf3_pkg::PIX_W-1:0] b_eff;
	logic                      s1_adv;

	// window and job build
	mf3_pkg::window_t win_q;
	mf3_pkg::window_t win_n;
	mf3_pkg::job_t    job_n;
	logic             have_ra;
	logic             have_rb;
	logic             have_ca;
	logic             have_cb;
	logic             job_need;

	// job queue and output sequencer
	mf3_pkg::job_t                 jobs_q [mf3_pkg::JOB_DEPTH];
	logic [mf3_pkg::JOB_PTR_W-1:0] wp_q;
	logic [mf3_pkg::JOB_PTR_W-1:0] rp_q;
	logic [mf3_pkg::JOB_CNT_W-1:0] jcnt_q;
	logic                          push;
	logic                          pop;
	mf3_pkg::job_t                 head;
	logic                          a_q;
	logic                          b_q;
	logic                          out_load;
	logic [8:0]                    sel_mask;
	logic [mf3_pkg::PIX_W-1:0]     med;
	logic                          out_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid;

	always_comb begin
		if (cfg_w_q == '0) begin
			uw = mf3_pkg::CFG_W_W'(1);
		end else if (cfg_w_q > mf3_pkg::CFG_W_W'(mf3_pkg::MAX_WIDTH)) begin
			uw = mf3_pkg::CFG_W_W'(mf3_pkg::MAX_WIDTH);
		end else begin
			uw = cfg_w_q;
		end
		if (cfg_h_q == '0) begin
			uh = mf3_pkg::CFG_H_W'(1);
		end else if (cfg_h_q > mf3_pkg::CFG_H_W'(mf3_pkg::MAX_HEIGHT)) begin
			uh = mf3_pkg::CFG_H_W'(mf3_pkg::MAX_HEIGHT);
		end else begin
			uh = cfg_h_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= mf3_pkg::CFG_W_W'(640);
			cfg_h_q <= mf3_pkg::CFG_H_W'(480);
		end else if (cfg_xfer) begin
			case (cfg_index)
				mf3_pkg::CFG_IDX_WIDTH:  cfg_w_q <= cfg_data[mf3_pkg::CFG_W_W-1:0];
				mf3_pkg::CFG_IDX_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take a pixel when the read stage is empty or moves on this cycle.
	assign pixel_ready = !s1_valid || s1_adv;
	assign in_xfer     = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_xfer) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if ({1'b0, col_q} + 11'd1 >= uw) begin
				col_q <= '0;
				if ({1'b0, row_q} + 13'd1 >= uh) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 12'd1;
				end
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_xfer) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	// A read that hits the column written in the same cycle takes the new data.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1    <= pixel_in;
			col_s1   <= col_q;
			row_s1   <= row_q;
			fwd_s1   <= s1_adv && (col_s1 == col_q);
			fwd_a_s1 <= px_s1;
			fwd_b_s1 <= a_eff;
		end
	end

	assign a_eff = fwd_s1 ? fwd_a_s1 : ram_a_rd;
	assign b_eff = fwd_s1 ? fwd_b_s1 : ram_b_rd;

	mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_a (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(px_s1),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(ram_a_rd)
	);

	mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_b (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata(a_eff),
		.re   (in_xfer),
		.raddr(col_q),
		.rdata(ram_b_rd)
	);

	// Shift the window left and drop the new column in on the right.
	always_comb begin
		for (int wr = 0; wr < 3; wr++) begin
			win_n[wr*3+0] = win_q[wr*3+1];
			win_n[wr*3+1] = win_q[wr*3+2];
		end
		win_n[2] = b_eff;
		win_n[5] = a_eff;
		win_n[8] = px_s1;
	end

	// Centre row one back, plus the current row on the last row; same for columns.
	always_comb begin
		have_ra  = row_s1 != '0;
		have_rb  = {1'b0, row_s1} == (uh - 13'd1);
		have_ca  = col_s1 != '0;
		have_cb  = {1'b0, col_s1} == (uw - 11'd1);
		job_need = (have_ra || have_rb) && (have_ca || have_cb);

		job_n.win      = win_n;
		job_n.rmask[0] = have_ra ? {2'b11, row_s1 >= 12'd2} : {1'b1, have_ra, 1'b0};
		job_n.rnum[0]  = have_ra ? row_s1 - 12'd1 : row_s1;
		job_n.rlast[0] = !have_ra;
		job_n.rmask[1] = {1'b1, have_ra, 1'b0};
		job_n.rnum[1]  = row_s1;
		job_n.rlast[1] = 1'b1;
		job_n.nr2      = have_ra && have_rb;
		job_n.cmask[0] = have_ca ? {2'b11, col_s1 >= 10'd2} : {1'b1, have_ca, 1'b0};
		job_n.cnum[0]  = have_ca ? col_s1 - 10'd1 : col_s1;
		job_n.clast[0] = !have_ca;
		job_n.cmask[1] = {1'b1, have_ca, 1'b0};
		job_n.cnum[1]  = col_s1;
		job_n.clast[1] = 1'b1;
		job_n.nc2      = have_ca && have_cb;
	end

	assign s1_adv = s1_valid &&
		(!job_need || (jcnt_q != mf3_pkg::JOB_CNT_W'(mf3_pkg::JOB_DEPTH)));
	assign push   = s1_adv && job_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_xfer) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			jobs_q[wp_q] <= job_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			jcnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   jcnt_q <= jcnt_q + 1'b1;
				2'b01:   jcnt_q <= jcnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Walk the head job's results, rows upper first, columns left first.
	assign head     = jobs_q[rp_q];
	assign out_load = (jcnt_q != '0) && (!out_valid_q || out_ready);
	assign pop      = out_load && (!head.nr2 || a_q) && (!head.nc2 || b_q);

	always_comb begin
		for (int wr = 0; wr < 3; wr++) begin
			for (int wc = 0; wc < 3; wc++) begin
				sel_mask[wr*3+wc] = head.rmask[a_q][wr] & head.cmask[b_q][wc];
			end
		end
	end

	mf3_median u_median (
		.vals(head.win),
		.mask(sel_mask),
		.med (med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q         <= 1'b0;
			b_q         <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!head.nc2 || b_q) begin
					b_q <= 1'b0;
					a_q <= (!head.nr2 || a_q) ? 1'b0 : 1'b1;
				end else begin
					b_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_out <= med;
			out_row    <= head.rnum[a_q];
			out_col    <= head.cnum[b_q];
			frame_done <= head.rlast[a_q] & head.clast[b_q];
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ----- hw/rtl/mf3_checker.sv -----
// Port-level checker of the median filter top level, with its bind.
`default_nettype none
module mf3_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          cfg_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [mf3_pkg::PIX_W-1:0]     median_out,
	input wire logic [mf3_pkg::ROW_W-1:0]     out_row,
	input wire logic [mf3_pkg::COL_W-1:0]     out_col,
	input wire logic                          frame_done
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_out) &&
		$stable(out_row) && $stable(out_col) && $stable(frame_done))
		else $error("stalled result changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");
endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.median_out(median_out),
	.out_row   (out_row),
	.out_col   (out_col),
	.frame_done(frame_done)
);
`default_nettype wire
